// File: design/ted_pkg.sv
// Shared types for the token edit distance block.
// No dependencies; used by token_edit_distance.
package ted_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    FUNC_SOURCE = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

endpackage

// File: design/token_edit_distance.sv
// Levenshtein edit distance over sequences of multi-byte tokens.
// Depends on ted_pkg for the state and function codes.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------
//   input   | in_valid, in_stall  | func, token, token_bytes
//   output  | out_valid, out_stall| distance, overflow
//
// A source token or an ignored item is taken in S_IDLE without leaving it. A target
// token walks the source in S_WALK and then S_DRAIN, or neither against an empty source:
// the row memory is read and written back one entry a cycle, the next read overlapping
// the current write. A finish item waits in S_FIN for the output register to be free.
// Reset clears the lengths and the overflow flag; the memories need no clearing.
// The input stalls while an item is in progress, but not for a waiting result.
module token_edit_distance #(
  parameter int MAX_LEN     = 256,
  parameter int TOKEN_BYTES = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic [8*TOKEN_BYTES-1:0]            token,
  input  logic [$clog2(TOKEN_BYTES+1)-1:0]    token_bytes,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(MAX_LEN+1)-1:0]        distance,
  output logic                                overflow
);

  localparam int TOK_W   = 8 * TOKEN_BYTES;
  localparam int BYTES_W = $clog2(TOKEN_BYTES + 1);
  localparam int KEY_W   = TOK_W + BYTES_W;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SRC_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  ted_pkg::state_t state, state_next;

  logic [KEY_W-1:0] src_mem [MAX_LEN];
  logic [CNT_W-1:0] row_mem [MAX_LEN+1];

  logic [CNT_W-1:0] src_count;
  logic [CNT_W-1:0] tgt_count;
  logic             ovf_seen;
  logic [KEY_W-1:0] key;
  logic             first;
  logic [CNT_W-1:0] idx;
  logic             cmp_valid;
  logic [CNT_W-1:0] cmp_idx;
  logic [CNT_W-1:0] left;
  logic [CNT_W-1:0] diag;
  logic [KEY_W-1:0] src_q;
  logic [CNT_W-1:0] row_q;

  logic             accept;
  logic             slot_free;
  logic             src_write;
  logic             tgt_start;
  logic             out_load;
  logic [CNT_W-1:0] row_raddr;
  logic [SRC_AW-1:0] src_raddr;
  logic [CNT_W-1:0] above;
  logic [CNT_W-1:0] min_ab;
  logic [CNT_W-1:0] min_abl;
  logic [CNT_W-1:0] row_entry;
  logic             row_we;
  logic [CNT_W-1:0] row_waddr;
  logic [CNT_W-1:0] row_wdata;
  logic [CNT_W-1:0] fin_dist;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Before the first target token the row holds 0..n, so that value stands in
  // for the memory read instead of an initialising pass.
  assign above     = first ? cmp_idx : row_q;
  assign min_ab    = (diag < above) ? diag : above;
  assign min_abl   = (min_ab < left) ? min_ab : left;
  assign row_entry = (src_q == key) ? diag : min_abl + CNT_W'(1);

  assign row_raddr = (state == ted_pkg::S_WALK) ? idx : src_count;
  assign src_raddr = SRC_AW'(idx - CNT_W'(1));

  assign fin_dist = ovf_seen ? MAX_CNT : ((tgt_count == '0) ? src_count : row_q);

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    src_write  = 1'b0;
    tgt_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ted_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (ted_pkg::func_t'(func))
            ted_pkg::FUNC_SOURCE: begin
              src_write = (tgt_count == '0) && (src_count < MAX_CNT);
            end
            ted_pkg::FUNC_TARGET: begin
              if (tgt_count < MAX_CNT) begin
                tgt_start = 1'b1;
                if (src_count != '0) begin
                  state_next = ted_pkg::S_WALK;
                end
              end
            end
            ted_pkg::FUNC_FINISH: begin
              state_next = ted_pkg::S_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      ted_pkg::S_WALK: begin
        if (idx == src_count) begin
          state_next = ted_pkg::S_DRAIN;
        end
      end
      ted_pkg::S_DRAIN: begin
        state_next = ted_pkg::S_IDLE;
      end
      ted_pkg::S_FIN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ted_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ted_pkg::S_IDLE;
      end
    endcase
  end

  // One write port on the row memory: the first entry at the start of a
  // target token, otherwise the entry just computed.
  always_comb begin
    row_we    = 1'b0;
    row_waddr = cmp_idx;
    row_wdata = row_entry;
    if (tgt_start) begin
      row_we    = 1'b1;
      row_waddr = '0;
      row_wdata = tgt_count + CNT_W'(1);
    end else if (cmp_valid) begin
      row_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (src_write) begin
      src_mem[src_count[SRC_AW-1:0]] <= {token_bytes, token};
    end
    src_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ted_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_count <= '0;
      tgt_count <= '0;
      ovf_seen  <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == ted_pkg::S_WALK);
      if (accept && ted_pkg::func_t'(func) == ted_pkg::FUNC_SOURCE
          && tgt_count == '0 && src_count >= MAX_CNT) begin
        ovf_seen <= 1'b1;
      end
      if (accept && ted_pkg::func_t'(func) == ted_pkg::FUNC_TARGET
          && tgt_count >= MAX_CNT) begin
        ovf_seen <= 1'b1;
      end
      if (src_write) begin
        src_count <= src_count + CNT_W'(1);
      end
      if (tgt_start) begin
        tgt_count <= tgt_count + CNT_W'(1);
      end
      if (out_load) begin
        src_count <= '0;
        tgt_count <= '0;
        ovf_seen  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_start) begin
      key   <= {token_bytes, token};
      first <= (tgt_count == '0);
      left  <= tgt_count + CNT_W'(1);
      diag  <= tgt_count;
      idx   <= CNT_W'(1);
    end else begin
      if (state == ted_pkg::S_WALK) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmp_valid) begin
        left <= row_entry;
        diag <= above;
      end
    end
    cmp_idx <= idx;
    if (out_load) begin
      distance <= fin_dist;
      overflow <= ovf_seen;
    end
  end

endmodule

// File: test/testbench.sv
// Self-checking testbench for token_edit_distance: a queue-fed driver, a stall generator
// and a monitor that checks each distance against an in-bench row-by-row predictor.
// Depends on ted_pkg for the function codes and on the token_edit_distance RTL.
module testbench;

  localparam int MAX_LEN     = 256;
  localparam int TOKEN_BYTES = 6;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    ted_pkg::func_t op;
    bit [47:0]      tok;
    bit [2:0]       nb;
    bit             pause;
    bit             hold;
    bit             calm;
  } pending_t;

  typedef struct {
    bit [8:0] dist_val;
    bit       ovf;
  } dist_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = 2'd0;
  logic [47:0] token = 48'd0;
  logic [2:0]  token_bytes = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  distance;
  logic        overflow;

  pending_t     pending_items[$];
  dist_result_t expected_results[$];
  pending_t     cur_item;

  // Predictor state: stored source characters and the current distance row.
  bit [50:0]   src_mem [MAX_LEN];
  int unsigned dist_row [MAX_LEN+1];
  int unsigned src_len = 0;
  int unsigned tgt_len = 0;
  bit          ovf_seen = 1'b0;

  int  errors = 0;
  bit  in_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  calm_now = 1'b0;
  int  gap_left = 0;
  int  quiet_left = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  bit  mark_calm = 1'b0;
  bit  next_pause = 1'b0;
  bit  next_hold = 1'b0;

  token_edit_distance #(
    .MAX_LEN    (MAX_LEN),
    .TOKEN_BYTES(TOKEN_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .token      (token),
    .token_bytes(token_bytes),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance   (distance),
    .overflow   (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advances the edit distance state by one accepted item.
  task automatic advance_distance(input pending_t it);
    bit [50:0]    key;
    int unsigned  diag;
    int unsigned  above;
    int unsigned  best;
    int unsigned  i;
    dist_result_t res;
    key = {it.nb, it.tok};
    case (it.op)
      ted_pkg::FUNC_SOURCE: begin
        if (tgt_len == 0) begin
          if (src_len >= MAX_LEN) begin
            ovf_seen = 1'b1;
          end else begin
            src_mem[src_len] = key;
            src_len++;
          end
        end
      end
      ted_pkg::FUNC_TARGET: begin
        if (tgt_len >= MAX_LEN) begin
          ovf_seen = 1'b1;
        end else begin
          if (tgt_len == 0) begin
            for (i = 0; i <= src_len; i++) dist_row[i] = i;
          end
          tgt_len++;
          diag = dist_row[0];
          dist_row[0] = tgt_len;
          for (i = 1; i <= src_len; i++) begin
            above = dist_row[i];
            if (src_mem[i-1] == key) begin
              dist_row[i] = diag;
            end else begin
              best = diag < above ? diag : above;
              best = best < dist_row[i-1] ? best : dist_row[i-1];
              dist_row[i] = best + 1;
            end
            diag = above;
          end
        end
      end
      ted_pkg::FUNC_FINISH: begin
        if (ovf_seen) best = MAX_LEN;
        else if (tgt_len == 0) best = src_len;
        else best = dist_row[src_len];
        if (best > MAX_LEN) best = MAX_LEN;
        res.dist_val = best[8:0];
        res.ovf      = ovf_seen;
        expected_results.insert(expected_results.size(), res);
        src_len  = 0;
        tgt_len  = 0;
        ovf_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_item(input ted_pkg::func_t op, input bit [47:0] tok, input bit [2:0] nb);
    pending_t it;
    it.op    = op;
    it.tok   = tok;
    it.nb    = nb;
    it.pause = next_pause;
    it.hold  = next_hold;
    it.calm  = mark_calm;
    next_pause = 1'b0;
    next_hold  = 1'b0;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Character bytes first-byte-most-significant; now and then the padding is left dirty.
  function automatic bit [47:0] rand_token(input bit [2:0] nb);
    bit [63:0] wide;
    bit [47:0] raw;
    wide = {$urandom(), $urandom()};
    raw  = wide[47:0];
    if (nb >= 1 && nb <= 6 && $urandom_range(9, 0) != 0)
      raw = raw & ({48{1'b1}} << ((6 - nb) * 8));
    return raw;
  endfunction

  function automatic int small_len();
    int r;
    r = $urandom_range(19, 0);
    if (r < 2) return 0;
    if (r < 17) return $urandom_range(10, 1);
    return $urandom_range(40, 11);
  endfunction

  // One source/target pair drawn from a small alphabet so that matches are common.
  // Noisy pairs get unused codes, late source characters and a missing finish now and then.
  task automatic add_pair(input int src_n, input int tgt_n, input bit noisy);
    bit [47:0] alpha_tok [8];
    bit [2:0]  alpha_nb [8];
    int        alpha_n;
    int        k;
    int        pick;
    alpha_n = $urandom_range(8, 1);
    for (k = 0; k < 8; k++) begin
      alpha_nb[k]  = 3'($urandom_range(7, 0));
      alpha_tok[k] = rand_token(alpha_nb[k]);
    end
    for (k = 0; k < src_n; k++) begin
      pick = $urandom_range(alpha_n - 1, 0);
      add_item(ted_pkg::FUNC_SOURCE, alpha_tok[pick], alpha_nb[pick]);
      if (noisy && $urandom_range(30, 0) == 0)
        add_item(ted_pkg::FUNC_NONE, rand_token(3'd7), 3'($urandom_range(7, 0)));
    end
    for (k = 0; k < tgt_n; k++) begin
      pick = $urandom_range(alpha_n - 1, 0);
      add_item(ted_pkg::FUNC_TARGET, alpha_tok[pick], alpha_nb[pick]);
      if (noisy && $urandom_range(19, 0) == 0)
        add_item(ted_pkg::FUNC_SOURCE, alpha_tok[pick], alpha_nb[pick]);
      if (noisy && $urandom_range(30, 0) == 0)
        add_item(ted_pkg::FUNC_NONE, rand_token(3'd7), 3'($urandom_range(7, 0)));
    end
    if (!noisy || $urandom_range(19, 0) != 0)
      add_item(ted_pkg::FUNC_FINISH, rand_token(3'd7), 3'($urandom_range(7, 0)));
  endtask

  // Driver: presents the next item once the previous transfer has completed.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].pause && expected_results.size() != 0)) begin
        cur_item = pending_items.pop_front();
        func        <= cur_item.op;
        token       <= cur_item.tok;
        token_bytes <= cur_item.nb;
        in_valid    <= 1'b1;
        if (cur_item.calm || quiet_left != 0) begin
          gap_left = 0;
          if (quiet_left != 0) quiet_left = quiet_left - 1;
        end else if ($urandom_range(49, 0) == 0) begin
          quiet_left = 40;
          gap_left = 0;
        end else if ($urandom_range(3, 0) == 0) begin
          gap_left = $urandom_range(13, 1);
        end else begin
          gap_left = 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (calm_now) begin
      out_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left = burst_left - 1;
    end else if ($urandom_range(19, 0) == 0) begin
      burst_left = 60;
      out_stall <= 1'b0;
    end else begin
      burst_left = $urandom_range(12, 0);
      out_stall <= ($urandom_range(2, 0) == 0);
    end
  end

  // Monitor: checks each result transfer, then feeds each accepted item to the predictor.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: distance %0d overflow %0d", distance, overflow);
        errors++;
      end else begin
        if (distance !== expected_results[0].dist_val) begin
          $error("distance: expected %0d, actual %0d", expected_results[0].dist_val,
                 distance);
          errors++;
        end
        if (overflow !== expected_results[0].ovf) begin
          $error("overflow: expected %0d, actual %0d", expected_results[0].ovf, overflow);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
    in_taken = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      in_taken = 1'b1;
      advance_distance(cur_item);
      if (cur_item.hold) hold_req = 1'b1;
      if (cur_item.calm) calm_now = 1'b1;
    end
  end

  initial begin
    int base;

    // Directed: empty pair, source only, target only.
    add_item(ted_pkg::FUNC_FINISH, 48'd0, 3'd0);
    add_item(ted_pkg::FUNC_SOURCE, 48'h4100_0000_0000, 3'd1);
    add_item(ted_pkg::FUNC_SOURCE, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_FINISH, 48'd0, 3'd0);
    add_item(ted_pkg::FUNC_TARGET, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_TARGET, 48'h4100_0000_0000, 3'd1);
    add_item(ted_pkg::FUNC_TARGET, 48'd0, 3'd0);
    add_item(ted_pkg::FUNC_FINISH, 48'hFFFF_FFFF_FFFF, 3'd7);
    // Equality takes in the byte count and the padding bits; an unused code in the middle.
    add_item(ted_pkg::FUNC_SOURCE, 48'hFFFF_FFFF_FFFF, 3'd7);
    add_item(ted_pkg::FUNC_SOURCE, 48'd0, 3'd0);
    add_item(ted_pkg::FUNC_SOURCE, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_TARGET, 48'hFFFF_FFFF_FFFF, 3'd6);
    add_item(ted_pkg::FUNC_NONE, 48'hFFFF_FFFF_FFFF, 3'd7);
    add_item(ted_pkg::FUNC_TARGET, 48'd0, 3'd0);
    add_item(ted_pkg::FUNC_TARGET, 48'hC3A9_0000_0001, 3'd2);
    add_item(ted_pkg::FUNC_TARGET, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_FINISH, 48'd0, 3'd0);
    // A source character after the first target is ignored.
    add_item(ted_pkg::FUNC_SOURCE, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_TARGET, 48'hC3A9_0000_0000, 3'd2);
    add_item(ted_pkg::FUNC_SOURCE, 48'h4100_0000_0000, 3'd1);
    add_item(ted_pkg::FUNC_FINISH, 48'd0, 3'd0);

    // Drain, then hold the receiver off while short pairs keep arriving.
    next_pause = 1'b1;
    next_hold  = 1'b1;
    repeat (6) add_pair(2, 2, 1'b0);

    base = pending_items.size();
    while (pending_items.size() - base < 60) begin
      if ($urandom_range(24, 0) == 0) next_pause = 1'b1;
      add_pair(small_len(), small_len(), 1'b1);
    end
    // Longest sequences: source beyond the limit with a full walk, target beyond it.
    add_pair(MAX_LEN + 1, 1, 1'b0);
    add_pair(0, MAX_LEN + 1, 1'b0);
    base = pending_items.size();
    while (pending_items.size() - base < 40) begin
      if ($urandom_range(24, 0) == 0) next_pause = 1'b1;
      add_pair(small_len(), small_len(), 1'b1);
    end
    // Closing stretch with no idling on either side.
    mark_calm = 1'b1;
    base = pending_items.size();
    while (pending_items.size() - base < 30) add_pair(small_len(), small_len(), 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #14000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
design/ted_pkg.sv
design/token_edit_distance.sv
test/testbench.sv
